// ----- src/lfu_pkg.sv -----
package lfu_pkg;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int STAMP_W = 64;
    localparam int CAP_W = 5;
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;
endpackage

// ----- src/lfu_cache_table.sv -----
// lfu_cache_table: fully associative lfu store, oldest touch breaks ties
// operation: an input beat is taken only while idle; o_stall stays high until the
// result has been taken, so a new operation waits until the last one is done;
// the scan reads one entry per cycle, then the write state writes the chosen slot
// back on a hit or a put, and the result is held while i_stall is high
// reset: synchronous active low; clears valid bits, touch clock, sets limit 16
module lfu_cache_table #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_lookup_key,
    input  logic [31:0] i_store_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [31:0] o_read_value,
    output logic        o_evicted,
    output logic [31:0] o_evicted_key
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_WRITE = 2'd2, S_OUT = 2'd3;

    lfu_pkg::t_entry mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid_bits;
    lfu_pkg::t_entry r_rd;
    logic [1:0] r_state;
    logic [IW:0] r_addr;       // address issued
    logic [IW-1:0] r_rd_idx;   // index of data in r_rd
    logic r_rd_live;
    logic r_cmd;
    logic [31:0] r_key, r_val;
    logic [lfu_pkg::CAP_W-1:0] r_cap;
    logic [63:0] r_clock;
    logic r_found;
    logic [IW-1:0] r_found_idx, r_free_idx, r_vic_idx;
    lfu_pkg::t_entry r_found_e, r_vic_e;
    logic r_has_free, r_has_vic;
    logic [CW-1:0] r_used;
    logic r_hit, r_ev;
    logic [31:0] r_rdv, r_evk;

    logic rd_ok, better;
    logic [CW-1:0] cap_eff;
    logic [IW-1:0] wr_idx;
    lfu_pkg::t_entry wr_e;
    logic wr_new, need_ev;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_hit = r_hit;
    assign o_read_value = r_rdv;
    assign o_evicted = r_ev;
    assign o_evicted_key = r_evk;

    assign rd_ok = r_rd_live && r_valid_bits[r_rd_idx];
    assign better = !r_has_vic || (r_rd.count < r_vic_e.count) ||
        (r_rd.count == r_vic_e.count && r_rd.stamp < r_vic_e.stamp);

    always_comb begin
        if (r_cap == '0) cap_eff = CW'(1);
        else if (32'(r_cap) > ENTRIES) cap_eff = CW'(ENTRIES);
        else cap_eff = CW'(r_cap);
        need_ev = (r_used >= cap_eff) || !r_has_free;
        wr_new = 1'b0;
        wr_idx = r_found_idx;
        wr_e = r_found_e;
        if (r_found) begin
            if (r_cmd == lfu_pkg::CMD_PUT) wr_e.value = r_val;
            if (r_found_e.count != '1) wr_e.count = r_found_e.count + 1'b1;
            wr_e.stamp = r_clock;
        end else begin
            wr_new = (r_cmd == lfu_pkg::CMD_PUT);
            wr_idx = need_ev ? r_vic_idx : r_free_idx;
            wr_e.key = r_key;
            wr_e.value = r_val;
            wr_e.count = 32'd1;
            wr_e.stamp = r_clock;
        end
    end

    // memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_addr[IW-1:0]];
        if (r_state == S_WRITE && (r_found || wr_new)) mem[wr_idx] <= wr_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid_bits <= '0;
            r_cap <= 5'd16;
            r_clock <= '0;
            r_rd_live <= 1'b0;
            r_addr <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_key <= i_lookup_key;
                        r_val <= i_store_value;
                        r_found <= 1'b0;
                        r_has_free <= 1'b0;
                        r_has_vic <= 1'b0;
                        r_used <= '0;
                        r_addr <= '0;
                        r_rd_live <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr < (IW+1)'(ENTRIES)) begin
                        r_rd_idx <= r_addr[IW-1:0];
                        r_rd_live <= 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end else begin
                        r_rd_live <= 1'b0;
                    end
                    if (r_rd_live) begin
                        if (rd_ok) begin
                            r_used <= r_used + 1'b1;
                            if (!r_found && r_rd.key == r_key) begin
                                r_found <= 1'b1;
                                r_found_idx <= r_rd_idx;
                                r_found_e <= r_rd;
                            end
                            if (better) begin
                                r_has_vic <= 1'b1;
                                r_vic_idx <= r_rd_idx;
                                r_vic_e <= r_rd;
                            end
                        end else if (!r_has_free) begin
                            r_has_free <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                    end
                    if (r_rd_live && r_rd_idx == IW'(ENTRIES-1)) r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_hit <= r_found;
                    r_rdv <= (r_found && r_cmd == lfu_pkg::CMD_GET) ?
                        r_found_e.value : lfu_pkg::MISS_VALUE;
                    r_ev <= wr_new && need_ev;
                    r_evk <= (wr_new && need_ev) ? r_vic_e.key : 32'd0;
                    if (r_found || wr_new) r_clock <= r_clock + 1'b1;
                    if (wr_new) r_valid_bits[wr_idx] <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/lfu_checker.sv -----
module lfu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_hit,
    input logic [31:0] o_read_value,
    input logic        o_evicted,
    input logic [31:0] o_evicted_key
);
    // a result beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_value) && $stable(o_hit))
        else $error("stalled result changed");
    // a miss returns all ones
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_read_value == 32'hFFFFFFFF)
        else $error("miss value wrong");
    // a hit never evicts
    a_noev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_evicted)
        else $error("hit evicted");
    // no new beat accepted while a result is shown
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("accepting during output");
endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);
